// ===== hw/rtl/monotone_chmax_weighted_sum_tree_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the weighted-sum tree unit.
// Every macro samples on i_clk and is held off while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef MONOTONE_CHMAX_WEIGHTED_SUM_TREE_UNIT_ASSERT_SVH
`define MONOTONE_CHMAX_WEIGHTED_SUM_TREE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define MCWST_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MCWST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/mcwst_pkg.sv =====
// ---------------------------------------------------------------------------
// mcwst_pkg
// Shared constants, leaf record type and modular helpers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mcwst_pkg;

    localparam int LEAVES = 2048;
    localparam int LEAF_W = 11;
    localparam int IDX_W  = 12;
    localparam int VAL_W  = 30;

    localparam logic [VAL_W-1:0] MODULUS = 30'd1000000007;

    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_UPDATE = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;
    localparam logic [1:0] KIND_CLEAR  = 2'd3;

    typedef struct packed {
        logic [VAL_W-1:0] val;
        logic [VAL_W-1:0] wt;
        logic [VAL_W-1:0] prod;
    } t_leaf;

    function automatic logic [VAL_W-1:0] mod_add(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        logic [VAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= {1'b0, MODULUS}) ? VAL_W'(s - {1'b0, MODULUS}) : VAL_W'(s);
    endfunction

    function automatic logic [VAL_W-1:0] mod_sub(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        logic [VAL_W:0] s;
        s = {1'b0, a} + {1'b0, MODULUS} - {1'b0, b};
        return (a >= b) ? VAL_W'(a - b) : VAL_W'(s);
    endfunction

endpackage

// ===== hw/rtl/monotone_chmax_weighted_sum_tree_unit.sv =====
// One item is in work at a time; the next transfer is accepted once the result is registered
// and the unit is back in idle. The pace is set by the 30-step serial modular multiplier and
// the registered read of the leaf memory.
// Reset is synchronous; afterwards a pass zeroes the leaf memory before any item.
// ---------------------------------------------------------------------------
// monotone_chmax_weighted_sum_tree_unit
// Leaf store of value, weight and product with a running total; serves load,
// monotone range chmax, range weighted sum and clear items.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module monotone_chmax_weighted_sum_tree_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [1:0]                 i_kind,
    input  logic [mcwst_pkg::LEAF_W-1:0] i_position,
    input  logic [mcwst_pkg::IDX_W-1:0]  i_range_low,
    input  logic [mcwst_pkg::IDX_W-1:0]  i_range_high,
    input  logic [mcwst_pkg::VAL_W-1:0]  i_new_value,
    input  logic [mcwst_pkg::VAL_W-1:0]  i_leaf_weight,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [mcwst_pkg::VAL_W-1:0]  o_weighted_sum
);
    import mcwst_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INIT = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_EVAL = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_SUB  = 3'd5;
    localparam logic [2:0] S_ADD  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    localparam logic [LEAF_W-1:0] LEAF_LAST = LEAF_W'(LEAVES - 1);
    localparam logic [IDX_W-1:0]  LEAF_CNT  = IDX_W'(LEAVES);
    localparam logic [4:0]        MUL_LAST  = 5'(VAL_W - 1);
    localparam logic [VAL_W+1:0]  P_EXT     = {2'b00, MODULUS};
    localparam logic [VAL_W+1:0]  TWO_P     = {1'b0, MODULUS, 1'b0};

    t_leaf r_mem [0:LEAVES-1];
    t_leaf r_rd;

    logic [2:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_hi, n_hi;
    logic [1:0]       r_kind, n_kind;
    logic [VAL_W-1:0] r_v, n_v;
    logic [VAL_W-1:0] r_w, n_w;
    logic [VAL_W-1:0] r_total, n_total;
    logic [VAL_W-1:0] r_acc, n_acc;
    logic [VAL_W-1:0] r_ma, n_ma;
    logic [VAL_W-1:0] r_mb, n_mb;
    logic [VAL_W-1:0] r_mr, n_mr;
    logic [4:0]       r_mcnt, n_mcnt;
    logic             r_out_valid, n_out_valid;
    logic [VAL_W-1:0] r_out_sum, n_out_sum;

    logic             w_en;
    t_leaf            w_data;
    logic             in_xfer;
    logic [IDX_W-1:0] lo_clamp, hi_clamp, idx_inc;
    logic [VAL_W+1:0] m_t;
    logic [VAL_W-1:0] m_red;

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_weighted_sum = r_out_sum;
    assign in_xfer        = i_in_valid && !o_in_stall;

    assign lo_clamp = (i_range_low > LEAF_CNT) ? LEAF_CNT : i_range_low;
    assign hi_clamp = (i_range_high > LEAF_CNT) ? LEAF_CNT : i_range_high;
    assign idx_inc  = IDX_W'(r_idx + IDX_W'(1));

    // One multiplier bit per cycle, most significant first; the partial
    // result stays below p, so the doubled sum stays below 3p.
    always_comb begin
        m_t = {1'b0, r_mr, 1'b0} + (r_mb[VAL_W-1] ? {2'b00, r_ma} : '0);
        if (m_t >= TWO_P) begin
            m_red = VAL_W'(m_t - TWO_P);
        end else if (m_t >= P_EXT) begin
            m_red = VAL_W'(m_t - P_EXT);
        end else begin
            m_red = VAL_W'(m_t);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_hi        = r_hi;
        n_kind      = r_kind;
        n_v         = r_v;
        n_w         = r_w;
        n_total     = r_total;
        n_acc       = r_acc;
        n_ma        = r_ma;
        n_mb        = r_mb;
        n_mr        = r_mr;
        n_mcnt      = r_mcnt;
        n_out_sum   = r_out_sum;
        n_out_valid = r_out_valid && i_out_stall;
        w_en        = 1'b0;
        w_data      = r_rd;

        unique case (r_state)
            S_INIT: begin
                w_en   = 1'b1;
                w_data = '0;
                n_idx  = idx_inc;
                if (r_idx[LEAF_W-1:0] == LEAF_LAST) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    n_kind = i_kind;
                    n_hi   = hi_clamp;
                    n_acc  = '0;
                    n_v    = (i_new_value >= MODULUS) ? VAL_W'(i_new_value - MODULUS)
                                                      : i_new_value;
                    n_w    = (i_leaf_weight >= MODULUS) ? VAL_W'(i_leaf_weight - MODULUS)
                                                        : i_leaf_weight;
                    unique case (i_kind) inside
                        KIND_LOAD: begin
                            n_idx   = {1'b0, i_position};
                            n_state = S_RD;
                        end
                        KIND_UPDATE, KIND_QUERY: begin
                            n_idx   = lo_clamp;
                            n_state = (lo_clamp < hi_clamp) ? S_RD : S_DONE;
                        end
                        default: begin
                            n_idx   = '0;
                            n_total = '0;
                            n_state = S_RD;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                n_mr   = '0;
                n_mcnt = '0;
                n_ma   = r_v;
                unique case (r_kind)
                    KIND_LOAD: begin
                        n_mb    = r_w;
                        n_state = S_MUL;
                    end
                    KIND_UPDATE: begin
                        // The first leaf already at or above the threshold ends the run.
                        n_mb    = r_rd.wt;
                        n_state = (r_rd.val >= r_v) ? S_DONE : S_MUL;
                    end
                    KIND_QUERY: begin
                        n_acc   = mod_add(r_acc, r_rd.prod);
                        n_idx   = idx_inc;
                        n_state = (idx_inc == r_hi) ? S_DONE : S_RD;
                    end
                    default: begin
                        w_en        = 1'b1;
                        w_data.val  = '0;
                        w_data.prod = '0;
                        n_idx       = idx_inc;
                        n_state     = (r_idx[LEAF_W-1:0] == LEAF_LAST) ? S_DONE : S_RD;
                    end
                endcase
            end
            S_MUL: begin
                n_mr   = m_red;
                n_mb   = {r_mb[VAL_W-2:0], 1'b0};
                n_mcnt = 5'(r_mcnt + 5'd1);
                if (r_mcnt == MUL_LAST) begin
                    n_state = S_SUB;
                end
            end
            S_SUB: begin
                n_total = mod_sub(r_total, r_rd.prod);
                n_state = S_ADD;
            end
            S_ADD: begin
                n_total     = mod_add(r_total, r_mr);
                w_en        = 1'b1;
                w_data.val  = r_v;
                w_data.wt   = (r_kind == KIND_LOAD) ? r_w : r_rd.wt;
                w_data.prod = r_mr;
                if (r_kind == KIND_LOAD) begin
                    n_state = S_DONE;
                end else begin
                    n_idx   = idx_inc;
                    n_state = (idx_inc == r_hi) ? S_DONE : S_RD;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_sum   = (r_kind == KIND_QUERY) ? r_acc : r_total;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[r_idx[LEAF_W-1:0]] <= w_data;
        end
        r_rd <= r_mem[r_idx[LEAF_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_idx       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi      <= n_hi;
        r_kind    <= n_kind;
        r_v       <= n_v;
        r_w       <= n_w;
        r_acc     <= n_acc;
        r_ma      <= n_ma;
        r_mb      <= n_mb;
        r_mr      <= n_mr;
        r_mcnt    <= n_mcnt;
        r_out_sum <= n_out_sum;
    end

`include "monotone_chmax_weighted_sum_tree_unit_assert.svh"

    `MCWST_ASSERT_NOW(a_total_reduced, 1'b1, r_total < MODULUS, "running total not reduced")
    `MCWST_ASSERT_NOW(a_out_reduced, r_out_valid, r_out_sum < MODULUS, "result not reduced")
    `MCWST_ASSERT_NOW(a_sweep_in_range,
        r_state == S_RD && (r_kind == KIND_QUERY || r_kind == KIND_UPDATE),
        r_idx < r_hi, "sweep index past range end")
    `MCWST_ASSERT_NEXT(a_done_delivers,
        r_state == S_DONE && !(r_out_valid && i_out_stall),
        r_out_valid && r_state == S_IDLE, "finished result not moved to output")

endmodule

// ===== dv/monotone_chmax_weighted_sum_tree_unit_tb.sv =====
// ---------------------------------------------------------------------------
// monotone_chmax_weighted_sum_tree_unit_tb
// Drives load, chmax update, range sum and clear transfers into the unit with
// random gaps and output stalls, predicts each weighted sum from a flat copy
// of the leaf values and weights, and compares every result in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

class weighted_sum_scoreboard;
    bit [29:0] leaf_val[mcwst_pkg::LEAVES];
    bit [29:0] leaf_wt[mcwst_pkg::LEAVES];
    bit [29:0] sums_due[$];
    int        errors;

    function bit [29:0] reduce(bit [29:0] x);
        return (x >= mcwst_pkg::MODULUS) ? x - mcwst_pkg::MODULUS : x;
    endfunction

    function void add_due(bit [29:0] s);
        sums_due = {sums_due, s};
    endfunction

    function bit [29:0] span_sum(int lo, int hi);
        longint acc;
        acc = 0;
        for (int i = lo; i < hi; i++) begin
            acc = (acc + (longint'(leaf_val[i]) * longint'(leaf_wt[i]))
                   % longint'(mcwst_pkg::MODULUS)) % longint'(mcwst_pkg::MODULUS);
        end
        return 30'(acc);
    endfunction

    function void note_input(bit [1:0] kind, bit [10:0] pos, bit [11:0] lo_in,
                             bit [11:0] hi_in, bit [29:0] v_in, bit [29:0] w_in);
        int        lo;
        int        hi;
        int        first_big;
        bit [29:0] v;
        bit [29:0] w;
        v  = reduce(v_in);
        w  = reduce(w_in);
        lo = (lo_in > mcwst_pkg::LEAVES) ? mcwst_pkg::LEAVES : lo_in;
        hi = (hi_in > mcwst_pkg::LEAVES) ? mcwst_pkg::LEAVES : hi_in;
        case (kind)
            mcwst_pkg::KIND_LOAD: begin
                if (pos < mcwst_pkg::LEAVES) begin
                    leaf_val[pos] = v;
                    leaf_wt[pos]  = w;
                end
                add_due(span_sum(0, mcwst_pkg::LEAVES));
            end
            mcwst_pkg::KIND_UPDATE: begin
                if (lo < hi) begin
                    // The first leaf already at or above the threshold stops the fill.
                    first_big = lo;
                    while (first_big < mcwst_pkg::LEAVES && leaf_val[first_big] < v)
                        first_big++;
                    if (first_big > hi)
                        first_big = hi;
                    for (int i = lo; i < first_big; i++)
                        leaf_val[i] = v;
                end
                add_due(span_sum(0, mcwst_pkg::LEAVES));
            end
            mcwst_pkg::KIND_QUERY: begin
                add_due((lo < hi) ? span_sum(lo, hi) : 30'd0);
            end
            default: begin
                foreach (leaf_val[i])
                    leaf_val[i] = '0;
                add_due(30'd0);
            end
        endcase
    endfunction

    function void check_result(bit [29:0] actual);
        bit [29:0] want;
        if (sums_due.size() == 0) begin
            $error("weighted_sum: unexpected result, actual %0d", actual);
            errors++;
            return;
        end
        want = sums_due.pop_front();
        if (want !== actual) begin
            $error("weighted_sum: expected %0d actual %0d", want, actual);
            errors++;
        end
    endfunction
endclass

module monotone_chmax_weighted_sum_tree_unit_tb;
    import mcwst_pkg::*;

    localparam int RANDOM_ITEMS = 780;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    logic [1:0]       i_kind = KIND_LOAD;
    logic [LEAF_W-1:0] i_position = '0;
    logic [IDX_W-1:0] i_range_low = '0;
    logic [IDX_W-1:0] i_range_high = '0;
    logic [VAL_W-1:0] i_new_value = '0;
    logic [VAL_W-1:0] i_leaf_weight = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    logic [VAL_W-1:0] o_weighted_sum;

    weighted_sum_scoreboard sb = new();
    int results_seen = 0;
    int send_calm = 0;

    monotone_chmax_weighted_sum_tree_unit DUT (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            sb.note_input(i_kind, i_position, i_range_low, i_range_high,
                          i_new_value, i_leaf_weight);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_weighted_sum);
            results_seen++;
        end
    end

    // Offers one item and returns at the edge where its transfer happens.
    task automatic send_item(bit [1:0] kind, bit [10:0] pos, bit [11:0] lo,
                             bit [11:0] hi, bit [29:0] v, bit [29:0] w);
        int  gap;
        bit  stalled;
        if (send_calm > 0) begin
            send_calm--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 19) == 0)
                send_calm = $urandom_range(10, 30);
            gap = $urandom_range(0, 9);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_kind        <= kind;
        i_position    <= pos;
        i_range_low   <= lo;
        i_range_high  <= hi;
        i_new_value   <= v;
        i_leaf_weight <= w;
        i_in_valid    <= 1'b1;
        forever begin
            @(negedge i_clk);
            stalled = o_in_stall;
            @(posedge i_clk);
            if (!stalled)
                break;
        end
    endtask

    function automatic bit [29:0] draw_residue();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return 30'($urandom_range(0, 200));
        else if (r < 9)
            return 30'($urandom_range(0, 1000000006));
        return 30'($urandom_range(1000000000, 1073741823));
    endfunction

    task automatic send_random_item();
        int        r;
        bit [1:0]  kind;
        bit [10:0] pos;
        bit [11:0] lo;
        bit [11:0] hi;
        r = $urandom_range(0, 99);
        if (r < 40)
            kind = KIND_LOAD;
        else if (r < 72)
            kind = KIND_UPDATE;
        else if (r < 99)
            kind = KIND_QUERY;
        else
            kind = KIND_CLEAR;
        pos = ($urandom_range(0, 99) < 85) ? 11'($urandom_range(0, 63))
                                           : 11'($urandom_range(0, 2047));
        r = $urandom_range(0, 99);
        if (r < 80)
            lo = 12'($urandom_range(0, 63));
        else if (r < 95)
            lo = 12'($urandom_range(0, 2047));
        else
            lo = 12'($urandom_range(0, 4095));
        // Wide ranges take long to sweep, so they stay rare.
        if ($urandom_range(0, 99) < 98)
            hi = 12'(lo + $urandom_range(0, 12));
        else
            hi = 12'($urandom_range(0, 4095));
        send_item(kind, pos, lo, hi, draw_residue(), draw_residue());
    endtask

    // Output side: a random stall before each transfer, one long hold-off.
    initial begin
        int  hold;
        int  calm;
        bit  offered;
        bit  held_long;
        calm = 0;
        held_long = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!held_long && results_seen >= 150) begin
                held_long = 1'b1;
                hold = 400;
            end else if (calm > 0) begin
                calm--;
                hold = 0;
            end else begin
                if ($urandom_range(0, 19) == 0)
                    calm = $urandom_range(10, 30);
                hold = $urandom_range(0, 9);
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            forever begin
                @(negedge i_clk);
                offered = o_out_valid;
                @(posedge i_clk);
                if (offered)
                    break;
            end
        end
    end

    initial begin
        int waited;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part.
        send_item(KIND_QUERY, 11'd0, 12'd0, 12'd2048, 30'd5, 30'd5);
        send_item(KIND_LOAD, 11'd0, 12'd0, 12'd0, 30'h3FFF_FFFF, 30'h3FFF_FFFF);
        send_item(KIND_LOAD, 11'd2047, 12'd0, 12'd0, 30'd1000000006, 30'd1000000006);
        send_item(KIND_LOAD, 11'd5, 12'd0, 12'd0, 30'd0, 30'd0);
        send_item(KIND_LOAD, 11'd3, 12'd0, 12'd0, 30'd50, 30'd7);
        send_item(KIND_LOAD, 11'd4, 12'd0, 12'd0, 30'd10, 30'd3);
        send_item(KIND_LOAD, 11'd6, 12'd0, 12'd0, 30'd100, 30'd11);
        send_item(KIND_UPDATE, 11'd0, 12'd4, 12'd4, 30'd999, 30'd0);
        send_item(KIND_UPDATE, 11'd0, 12'd3000, 12'd4095, 30'd999, 30'd0);
        send_item(KIND_UPDATE, 11'd0, 12'd3, 12'd8, 30'd20, 30'd0);
        send_item(KIND_UPDATE, 11'd0, 12'd4, 12'd8, 30'd60, 30'd0);
        send_item(KIND_UPDATE, 11'd0, 12'd1, 12'd3, 30'h3FFF_FFFF, 30'd0);
        send_item(KIND_QUERY, 11'd0, 12'd6, 12'd2, 30'd0, 30'd0);
        send_item(KIND_QUERY, 11'd0, 12'd0, 12'd8, 30'd0, 30'd0);
        send_item(KIND_QUERY, 11'd0, 12'd2040, 12'd4095, 30'd0, 30'd0);
        send_item(KIND_UPDATE, 11'd0, 12'd2040, 12'd4095, 30'd77, 30'd0);
        send_item(KIND_CLEAR, 11'd0, 12'd0, 12'd0, 30'd0, 30'd0);
        send_item(KIND_QUERY, 11'd0, 12'd0, 12'd4095, 30'd0, 30'd0);
        send_item(KIND_UPDATE, 11'd0, 12'd0, 12'd4095, 30'd123456789, 30'd0);
        send_item(KIND_LOAD, 11'd1024, 12'd0, 12'd0, 30'd555, 30'd1000000000);
        send_item(KIND_QUERY, 11'd0, 12'd1000, 12'd1030, 30'd0, 30'd0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) begin
                // Let the unit drain completely before going on.
                i_in_valid <= 1'b0;
                waited = 0;
                do begin
                    @(posedge i_clk);
                    waited++;
                end while (sb.sums_due.size() != 0 && waited < 200000);
            end
            send_random_item();
        end
        i_in_valid <= 1'b0;

        waited = 0;
        while (sb.sums_due.size() != 0 && waited < 200000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.sums_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end
endmodule
